// ===== hdl/rmf_pkg.sv =====
// Shared types and constants for the RGB 3x3 mean filter.
`default_nettype none

package rmf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WIDTH_W = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W = 14;
  localparam int POS_W = 16;
  localparam int CH_W = 8;
  localparam int NUM_CH = 3;
  localparam int PIX_W = CH_W * NUM_CH;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd768;

  // Window is indexed [column slot][row], slot 0 oldest column, row 0 oldest row.
  typedef logic [2:0][2:0][PIX_W-1:0] rmf_win_t;
  typedef logic [2:0][2:0][CH_W-1:0] rmf_cwin_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic [2:0] col_mask;
    logic [2:0] row_mask;
  } rmf_ctrl_t;

  typedef struct packed {
    logic en;
    logic [COL_W-1:0] col;
  } rmf_wr_t;

endpackage

`default_nettype wire

// ===== hdl/rgb_mean_filter_3x3.sv =====
// Top level of the streaming RGB 3x3 mean filter.
`default_nettype none

// Streaming 3x3 box filter for RGB frames sent in raster order. The block takes one item per
// clock while the output is free; the rate is set by the two line stores, each read and written
// once per pixel, and by three channel lanes that each sum the window and divide by one
// multiplication. A pixel's result leaves the output register after the item that completes
// its neighborhood, which is the item one row and one pixel later, so the first
// image_width + 1 pixels of a frame give no result. After the last pixel, further items,
// pad or not, release the rest of the frame; a pad item (tuser high) that arrives while
// pixels are still expected is dropped. tlast marks the final result of a frame. Writing
// image_width or image_height restarts the frame and must happen only while the block is idle.
module rgb_mean_filter_3x3 import rmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // in_red, in_green, in_blue
  input  logic                  s_tuser,   // pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [PIX_W-1:0]      m_tdata,   // out_red, out_green, out_blue
  output logic                  m_tlast    // last_of_frame
);

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic [POS_W-1:0]    col_p;
  logic [POS_W-1:0]    row_p;
  logic [POS_W-1:0]    w_p;
  logic [POS_W-1:0]    h_p;
  logic                adv;
  logic                receiving;
  logic                col_first;
  logic                take;
  logic                wrap;
  logic [PIX_W-1:0]    pix0;
  rmf_ctrl_t           ctrl0;
  logic                v1;
  logic                v2;
  logic                v3;
  rmf_ctrl_t           ctrl1;
  rmf_ctrl_t           ctrl2;
  logic [COL_W-1:0]    col1;
  logic [PIX_W-1:0]    pix1;
  logic                last3;
  rmf_wr_t             wr;
  rmf_win_t            win;
  rmf_cwin_t           cwin [NUM_CH];
  logic [CH_W-1:0]     lane_q [NUM_CH];

  always_comb begin
    if (image_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (POS_W'(image_width) > POS_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
  end

  assign h_eff = (image_height == '0) ? HEIGHT_W'(1) : image_height;
  assign col_p = POS_W'(col);
  assign row_p = POS_W'(row);
  assign w_p = POS_W'(w_eff);
  assign h_p = POS_W'(h_eff);

  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign receiving = row_p < h_p;
  assign col_first = (col == '0);
  assign take = s_tvalid && s_tready && !(receiving && s_tuser);
  assign pix0 = receiving ? s_tdata : '0;
  assign wrap = (col_p + POS_W'(1)) >= w_p;

  // Column zero closes the last pixel of the row before last; other columns close the
  // pixel to their left in the previous row.
  always_comb begin
    ctrl0.emit = col_first ? (row_p >= POS_W'(2)) : (row_p >= POS_W'(1));
    ctrl0.last = col_first && (row_p == h_p + POS_W'(1));
    ctrl0.col_mask = {!col_first, 1'b1,
                      col_first ? (w_p >= POS_W'(2)) : (col_p >= POS_W'(2))};
    ctrl0.row_mask = {col_first ? (row_p <= h_p) : (row_p < h_p), 1'b1,
                      col_first ? (row_p >= POS_W'(3)) : (row_p >= POS_W'(2))};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col <= '0;
      row <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: image_width <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
      endcase
      col <= '0;
      row <= '0;
    end else if (take) begin
      if (ctrl0.emit && ctrl0.last) begin
        col <= '0;
        row <= '0;
      end else if (wrap) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= take;
      v2 <= v1 && ctrl1.emit;
      v3 <= v2;
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl1 <= ctrl0;
      col1 <= col;
      pix1 <= pix0;
      ctrl2 <= ctrl1;
      last3 <= ctrl2.last;
      m_tlast <= last3;
    end
  end

  assign wr.en = v1;
  assign wr.col = col1;

  rmf_window u_window (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .rd_col (col),
    .wr     (wr),
    .pix    (pix1),
    .win    (win)
  );

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cwin[g][i][j] = win[i][j][g*CH_W +: CH_W];
        end
      end
    end

    rmf_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .win  (cwin[g]),
      .ctrl (ctrl2),
      .q    (lane_q[g])
    );

    assign m_tdata[g*CH_W +: CH_W] = lane_q[g];
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (take && ctrl0.emit && ctrl0.last && !cfg_we) |=> (col == '0 && row == '0))
    else $error("Counters did not clear after the final pixel of a frame.");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_p < w_p)
    else $error("Column counter ran past the image width.");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_p <= h_p + POS_W'(1))
    else $error("Row counter ran past the drain rows.");

endmodule

`default_nettype wire

// ===== hdl/rmf_window.sv =====
// Line stores, read forwarding and the 3x3 pixel window of the mean filter.
`default_nettype none

module rmf_window import rmf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [COL_W-1:0] rd_col,
  input  rmf_wr_t          wr,
  input  logic [PIX_W-1:0] pix,
  output rmf_win_t         win
);

  logic [PIX_W-1:0] row_store_prev [MAX_WIDTH];
  logic [PIX_W-1:0] row_store_prev2 [MAX_WIDTH];
  logic [PIX_W-1:0] prev_q;
  logic [PIX_W-1:0] prev2_q;
  logic [PIX_W-1:0] fwd_pix;
  logic [PIX_W-1:0] fwd_old1;
  logic [PIX_W-1:0] old1;
  logic [PIX_W-1:0] old2;
  logic             fwd;

  // Two items in a row on the same column (a one-pixel-wide frame, or the first item of a
  // frame right after the final item of the last one) read the column being written.
  assign old1 = fwd ? fwd_pix : prev_q;
  assign old2 = fwd ? fwd_old1 : prev2_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      prev_q <= row_store_prev[rd_col];
      prev2_q <= row_store_prev2[rd_col];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr.en) begin
      row_store_prev[wr.col] <= pix;
      row_store_prev2[wr.col] <= old1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (adv) begin
      fwd <= wr.en && (wr.col == rd_col);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_pix <= pix;
      fwd_old1 <= old1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr.en) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= {pix, old1, old2};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rmf_lane.sv =====
// One color channel lane: masked window sum and division by the neighbor count.
`default_nettype none

module rmf_lane import rmf_pkg::*; (
  input  logic            clk,
  input  logic            adv,
  input  rmf_cwin_t       win,
  input  rmf_ctrl_t       ctrl,
  output logic [CH_W-1:0] q
);

  localparam int SUM_W = 12;
  localparam int RECIP_W = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W = SUM_W + RECIP_W;

  // Reciprocal of the neighbor count, rounded up, scaled by two to the sixteenth.
  function automatic logic [RECIP_W-1:0] recip(input logic [2:0] cm, input logic [2:0] rm);
    logic [3:0] ncols;
    logic [3:0] nrows;
    logic [3:0] n;
    ncols = 4'(cm[0]) + 4'(cm[1]) + 4'(cm[2]);
    nrows = 4'(rm[0]) + 4'(rm[1]) + 4'(rm[2]);
    n = 4'(ncols * nrows);
    unique case (n)
      4'd2: recip = 17'd32768;
      4'd3: recip = 17'd21846;
      4'd4: recip = 17'd16384;
      4'd6: recip = 17'd10923;
      4'd9: recip = 17'd7282;
      default: recip = 17'd65536;
    endcase
  endfunction

  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_q;
  logic [RECIP_W-1:0] recip_q;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (ctrl.col_mask[i] && ctrl.row_mask[j]) begin
          sum = sum + SUM_W'(win[i][j]);
        end
      end
    end
  end

  assign prod = PROD_W'(sum_q) * PROD_W'(recip_q);

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_q <= sum;
      recip_q <= recip(ctrl.col_mask, ctrl.row_mask);
      q <= prod[RECIP_SHIFT +: CH_W];
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the streaming RGB 3x3 mean filter.
`timescale 1ns / 100ps

module tb_top;
  import rmf_pkg::*;

  localparam int unsigned NO_PAUSE = 32'hFFFF_FFFF;
  localparam int unsigned TARGET_ITEMS = 1950;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            pad;
  } pixel_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } mean_px_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [PIX_W-1:0]      m_tdata;
  logic                  m_tlast;

  rgb_mean_filter_3x3 u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter state mirrored by the predictor.
  logic [PIX_W-1:0]    line_prev [MAX_WIDTH];
  logic [PIX_W-1:0]    line_prev2 [MAX_WIDTH];
  logic [PIX_W-1:0]    win [3][3];
  logic [WIDTH_W-1:0]  reg_width = WIDTH_RESET;
  logic [HEIGHT_W-1:0] reg_height = HEIGHT_RESET;
  int unsigned         in_col, in_row, out_cnt;

  pixel_item_t pixel_queue[$];
  mean_px_t    expected_means[$];
  pixel_item_t cur_item;
  mean_px_t    seen_px, want_px;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0, hold_req = 0, hold_seen = 0;
  int unsigned item_count = 0;

  function automatic int unsigned eff_width();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_WIDTH) return MAX_WIDTH;
    return reg_width;
  endfunction

  function automatic int unsigned eff_height();
    return (reg_height == 0) ? 1 : reg_height;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_cnt = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win[i][j] = '0;
  endfunction

  function automatic mean_px_t window_mean(int unsigned s, int unsigned r, int unsigned c,
                                           int unsigned w, int unsigned h);
    int unsigned rlo, rhi, clo, chi, n;
    int unsigned sum [3];
    mean_px_t res;
    rlo = (r >= 1) ? 0 : 1;
    rhi = (r + 1 < h) ? 2 : 1;
    clo = (c >= 1) ? s - 1 : s;
    chi = (c + 1 < w) ? s + 1 : s;
    if (chi > 2) chi = 2;
    n = 0;
    for (int k = 0; k < 3; k++) sum[k] = 0;
    for (int unsigned i = clo; i <= chi; i++) begin
      for (int unsigned j = rlo; j <= rhi; j++) begin
        for (int k = 0; k < 3; k++) sum[k] += win[i][j][k*CH_W +: CH_W];
        n++;
      end
    end
    res.red = CH_W'(sum[0] / n);
    res.green = CH_W'(sum[1] / n);
    res.blue = CH_W'(sum[2] / n);
    res.last = 1'b0;
    return res;
  endfunction

  function automatic void shift_column(int unsigned c, logic [PIX_W-1:0] px);
    int unsigned idx;
    logic [PIX_W-1:0] old1, old2;
    idx = c % MAX_WIDTH;
    old2 = line_prev2[idx];
    old1 = line_prev[idx];
    line_prev2[idx] = old1;
    line_prev[idx] = px;
    for (int i = 0; i < 3; i++) begin
      win[0][i] = win[1][i];
      win[1][i] = win[2][i];
    end
    win[2][0] = old2;
    win[2][1] = old1;
    win[2][2] = px;
  endfunction

  function automatic void filter_step(pixel_item_t it);
    int unsigned w, h, total, c0, r0;
    logic [PIX_W-1:0] px;
    logic emit;
    mean_px_t res;
    w = eff_width();
    h = eff_height();
    total = w * h;
    c0 = in_col;
    r0 = in_row;
    px = '0;
    emit = 1'b0;
    if (r0 < h) begin
      if (it.pad) return;
      px = {it.blue, it.green, it.red};
    end
    if (c0 == 0) begin
      if (r0 >= 2 && out_cnt < total) begin
        res = window_mean(2, r0 - 2, w - 1, w, h);
        emit = 1'b1;
      end
      shift_column(c0, px);
    end else begin
      shift_column(c0, px);
      if (r0 >= 1 && out_cnt < total) begin
        res = window_mean(1, r0 - 1, c0 - 1, w, h);
        emit = 1'b1;
      end
    end
    in_col = c0 + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row = r0 + 1;
    end
    if (emit) begin
      res.last = (out_cnt + 1 == total);
      out_cnt++;
      expected_means.push_back(res);
      if (out_cnt >= total) restart_frame();
    end
  endfunction

  // Sender: offers queued items and feeds each accepted item to the predictor.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) filter_step(cur_item);
      if (!s_tvalid || s_tready) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pixel_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {cur_item.blue, cur_item.green, cur_item.red};
          s_tuser <= cur_item.pad;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker for results leaving the block.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_px = '{red: m_tdata[0 +: CH_W], green: m_tdata[CH_W +: CH_W],
                  blue: m_tdata[2*CH_W +: CH_W], last: m_tlast};
      if (expected_means.size() == 0) begin
        error_count++;
        $display("%0t: expected no result, actual %0d/%0d/%0d/%0b",
                 $time, seen_px.red, seen_px.green, seen_px.blue, seen_px.last);
      end else begin
        want_px = expected_means.pop_front();
        if (seen_px !== want_px) begin
          error_count++;
          $display("%0t: expected %0d/%0d/%0d/%0b, actual %0d/%0d/%0d/%0b",
                   $time, want_px.red, want_px.green, want_px.blue, want_px.last,
                   seen_px.red, seen_px.green, seen_px.blue, seen_px.last);
        end
      end
    end
  end

  function automatic logic [CH_W-1:0] rand_chan();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CH_W'($urandom_range(255));
  endfunction

  function automatic void push_item(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                    logic [CH_W-1:0] b, logic pad);
    pixel_queue.push_back('{red: r, green: g, blue: b, pad: pad});
    item_count++;
  endfunction

  task automatic wait_quiet();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || s_tvalid || expected_means.size() != 0);
  endtask

  task automatic settle();
    wait_quiet();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    if (idx == CFG_IMAGE_WIDTH) reg_width = WIDTH_W'(value);
    else reg_height = HEIGHT_W'(value);
    restart_frame();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Queues the pixels of one frame, stopping after pix_limit pixels; a complete frame is
  // followed by its drain items. At pause_at it waits until every queued item is sent and every pending result checked.
  task automatic push_frame(int unsigned pix_limit, int unsigned pause_at);
    int unsigned w, total;
    w = eff_width();
    total = w * eff_height();
    for (int unsigned p = 0; p < total && p < pix_limit; p++) begin
      if (p == pause_at) wait_quiet();
      if ($urandom_range(99) < 4) push_item(rand_chan(), rand_chan(), rand_chan(), 1'b1);
      push_item(rand_chan(), rand_chan(), rand_chan(), 1'b0);
    end
    if (pix_limit >= total) begin
      for (int unsigned d = 0; d <= w; d++) begin
        if ($urandom_range(99) < 80) push_item(rand_chan(), rand_chan(), rand_chan(), 1'b1);
        else push_item(rand_chan(), rand_chan(), rand_chan(), 1'b0);
      end
    end
  endtask

  int unsigned phase, new_w, new_h, total, limit, n_frames;

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_prev[i] = '0;
      line_prev2[i] = '0;
    end
    restart_frame();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A one-pixel frame from zero sizes, with a pad before the pixel and a pixel among drains.
    set_idle(0, 0);
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, 0);
    push_item(8'h00, 8'h00, 8'h00, 1'b1);
    push_item(8'hFF, 8'h00, 8'hFF, 1'b0);
    push_item(8'h12, 8'hFF, 8'h34, 1'b0);
    push_item(8'hAA, 8'h55, 8'hAA, 1'b1);
    settle();

    // A 3x3 frame of extreme values with a pad item in the middle.
    write_reg(CFG_IMAGE_WIDTH, 3);
    write_reg(CFG_IMAGE_HEIGHT, 3);
    for (int unsigned p = 0; p < 9; p++) begin
      if (p == 4) push_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
      if (p[0]) push_item(8'hFF, 8'h00, 8'hFF, 1'b0);
      else push_item(8'h00, 8'hFF, 8'h01, 1'b0);
    end
    push_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_item(8'h00, 8'h00, 8'h00, 1'b1);
    push_item(8'h80, 8'h7F, 8'h80, 1'b1);
    settle();

    // Size extremes, each frame cut short by the next register write.
    set_idle(21, 21);
    write_reg(CFG_IMAGE_WIDTH, 2047);
    write_reg(CFG_IMAGE_HEIGHT, 8191);
    push_frame(1030, NO_PAUSE);
    settle();
    write_reg(CFG_IMAGE_WIDTH, MAX_WIDTH);
    write_reg(CFG_IMAGE_HEIGHT, 8191);
    push_frame(30, NO_PAUSE);
    settle();
    write_reg(CFG_IMAGE_WIDTH, 1);
    write_reg(CFG_IMAGE_HEIGHT, 4096);
    push_frame(150, NO_PAUSE);
    settle();
    write_reg(CFG_IMAGE_WIDTH, 2);
    write_reg(CFG_IMAGE_HEIGHT, 8191);
    push_frame(100, NO_PAUSE);
    settle();

    // Output held off for a long stretch while the sender keeps offering items.
    set_idle(0, 0);
    write_reg(CFG_IMAGE_WIDTH, 8);
    write_reg(CFG_IMAGE_HEIGHT, 8);
    hold_req = hold_req + 1;
    push_frame(NO_PAUSE, 32);
    settle();

    phase = 0;
    while (item_count < TARGET_ITEMS || phase < 4) begin
      case (phase % 4)
        0: set_idle(0, 0);
        1: set_idle(62, 0);
        2: set_idle(0, 62);
        default: set_idle(21, 21);
      endcase
      new_w = $urandom_range(99);
      if (new_w < 5) new_w = 0;
      else if (new_w < 12) new_w = $urandom_range(40, 13);
      else new_w = $urandom_range(12, 1);
      new_h = ($urandom_range(99) < 5) ? 0 : $urandom_range(8, 1);
      case ($urandom_range(2))
        0: begin
          write_reg(CFG_IMAGE_WIDTH, new_w);
          write_reg(CFG_IMAGE_HEIGHT, new_h);
        end
        1: write_reg(CFG_IMAGE_WIDTH, new_w);
        default: write_reg(CFG_IMAGE_HEIGHT, new_h);
      endcase
      total = eff_width() * eff_height();
      n_frames = $urandom_range(3, 1);
      for (int unsigned f = 0; f < n_frames; f++) begin
        limit = ($urandom_range(9) == 0) ? $urandom_range(total) : NO_PAUSE;
        push_frame(limit, ($urandom_range(7) == 0) ? $urandom_range(total) : NO_PAUSE);
        if (limit < total) break;
      end
      settle();
      phase++;
    end

    settle();
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
